/* hdl/ple_pkg.sv */
package ple_pkg;

   localparam int DATA_W      = 32;
   localparam int POS_W       = 6;
   localparam int MAX_RESULTS = 32;
   localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [3:0] OP_INS_FRONT = 4'd0;
   localparam logic [3:0] OP_INS_AT    = 4'd1;
   localparam logic [3:0] OP_INS_BACK  = 4'd2;
   localparam logic [3:0] OP_DEL_FRONT = 4'd3;
   localparam logic [3:0] OP_DEL_AT    = 4'd4;
   localparam logic [3:0] OP_DEL_BACK  = 4'd5;
   localparam logic [3:0] OP_LIST      = 4'd6;
   localparam logic [3:0] OP_SEARCH    = 4'd7;
   localparam logic [3:0] OP_COUNT     = 4'd8;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_BADPOS   = 3'd1;
   localparam logic [2:0] STATUS_EMPTY    = 3'd2;
   localparam logic [2:0] STATUS_FULL     = 3'd3;
   localparam logic [2:0] STATUS_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [3:0]              op;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic signed [DATA_W-1:0] item_value;
      logic [4:0]              item_position;
      logic [5:0]              count;
      logic                    last;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [POS_W-1:0]        pos;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_WALK,
      STATE_FINISH
   } state_type;

endpackage

/* hdl/ple_cell.sv */
module ple_cell (
   input  logic                               clock,
   input  ple_pkg::cell_cmd_type              cmd,
   input  logic [ple_pkg::POS_W-1:0]          index,
   input  logic signed [ple_pkg::DATA_W-1:0]  left_value,
   input  logic signed [ple_pkg::DATA_W-1:0]  right_value,
   output logic signed [ple_pkg::DATA_W-1:0]  value
);

   logic signed [ple_pkg::DATA_W-1:0] value_ff;
   logic signed [ple_pkg::DATA_W-1:0] value_in;

   // Each cell decides on its own whether it takes part in a shift.
   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         ple_pkg::CELL_INSERT: begin
            if (index == cmd.pos) begin
               value_in = cmd.value;
            end else if (index > cmd.pos) begin
               value_in = left_value;
            end
         end
         ple_pkg::CELL_DELETE: begin
            if (index >= cmd.pos) begin
               value_in = right_value;
            end
         end
         ple_pkg::CELL_ROTATE: begin
            value_in = right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* hdl/positional_list_engine_top.sv */
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values.
// Requests arrive on the req_ channel (operation, value, position) and results
// leave on the rsp_ channel; a transaction moves when valid is high and stall is low.
// Insert and delete transactions shift the affected cells and give one result in
// the next cycle, so they sustain one transaction every cycle while rsp_stall is low.
// List and search rotate the whole cell ring once, one cell per cycle while the
// receiver does not stall. A list holds off the next request until the rotation
// is done; a search then passes a closing FINISH state. Each listed entry or search
// match becomes one result, the final one of a run marked with last.
// A search holds each match back until the next one is found, so that last can
// be set on the true final match; the closing state sends it (or not found).
// Runs stop after 32 results, but the rotation always completes so that the
// list comes back in order.
// When the receiver stalls, the result register holds and the ring pauses;
// no request is taken until the result slot is free.
// Reset clears the length to zero and the control state; entry values are
// left as they are and are never read before being written.
module positional_list_engine_top #(
   parameter int CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ple_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ple_pkg::rsp_type rsp_data
);

   localparam int LW   = $clog2(CAPACITY + 1);
   localparam int IW   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CMPW = (LW > ple_pkg::POS_W) ? LW : ple_pkg::POS_W;

   ple_pkg::state_type    state_ff, state_in;
   logic [LW-1:0]         len_ff, len_in;
   logic [IW-1:0]         step_ff, step_in;
   logic [ple_pkg::HIT_W-1:0] hits_ff, hits_in;
   logic                  walk_list_ff, walk_list_in;
   logic signed [ple_pkg::DATA_W-1:0] key_ff, key_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic signed [ple_pkg::DATA_W-1:0] pend_value_ff, pend_value_in;
   logic [4:0]            pend_pos_ff, pend_pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ple_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   ple_pkg::cell_cmd_type cmd;
   logic signed [ple_pkg::DATA_W-1:0] cell_value [CAPACITY];
   logic signed [ple_pkg::DATA_W-1:0] head;

   logic can_emit;
   logic accept;
   logic is_full;
   logic is_empty;
   logic in_range;
   logic emit_now;
   logic [ple_pkg::POS_W-1:0] op_pos;
   logic [2:0] status;

   // Ring of cells, ends joined: on an insert, cells past the position take the left
   // neighbor; on a delete, cells from it on, and on a rotation all, take the right.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ple_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .index       (ple_pkg::POS_W'(i)),
         .left_value  (cell_value[(i + CAPACITY - 1) % CAPACITY]),
         .right_value (cell_value[(i + 1) % CAPACITY]),
         .value       (cell_value[i])
      );
   end

   assign head      = cell_value[0];
   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ple_pkg::STATE_IDLE) || !can_emit;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (len_ff == LW'(CAPACITY));
   assign is_empty  = (len_ff == '0);
   assign in_range  = (LW'(step_ff) < len_ff);

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      step_in       = step_ff;
      hits_in       = hits_ff;
      walk_list_in  = walk_list_ff;
      key_in        = key_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      pend_pos_in   = pend_pos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      cmd.op        = ple_pkg::CELL_HOLD;
      cmd.pos       = '0;
      cmd.value     = req_data.value;
      op_pos        = '0;
      status        = ple_pkg::STATUS_OK;
      emit_now      = 1'b0;

      unique case (state_ff)
         ple_pkg::STATE_IDLE: begin
            if (accept) begin
               emit_now = 1'b1;
               case (req_data.op) inside
                  ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_AT, ple_pkg::OP_INS_BACK: begin
                     if (req_data.op == ple_pkg::OP_INS_AT) begin
                        op_pos = req_data.position;
                     end else if (req_data.op == ple_pkg::OP_INS_BACK) begin
                        op_pos = ple_pkg::POS_W'(len_ff);
                     end
                     if (is_full) begin
                        status = ple_pkg::STATUS_FULL;
                     end else if (CMPW'(op_pos) > CMPW'(len_ff)) begin
                        status = ple_pkg::STATUS_BADPOS;
                     end else begin
                        cmd.op  = ple_pkg::CELL_INSERT;
                        cmd.pos = op_pos;
                        len_in  = len_ff + LW'(1);
                     end
                  end
                  ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_AT, ple_pkg::OP_DEL_BACK: begin
                     if (req_data.op == ple_pkg::OP_DEL_AT) begin
                        op_pos = req_data.position;
                     end else if (req_data.op == ple_pkg::OP_DEL_BACK) begin
                        op_pos = ple_pkg::POS_W'(len_ff - LW'(1));
                     end
                     if (is_empty) begin
                        status = ple_pkg::STATUS_EMPTY;
                     end else if (CMPW'(op_pos) >= CMPW'(len_ff)) begin
                        status = ple_pkg::STATUS_BADPOS;
                     end else begin
                        cmd.op  = ple_pkg::CELL_DELETE;
                        cmd.pos = op_pos;
                        len_in  = len_ff - LW'(1);
                     end
                  end
                  ple_pkg::OP_LIST: begin
                     if (is_empty) begin
                        status = ple_pkg::STATUS_EMPTY;
                     end else begin
                        emit_now     = 1'b0;
                        state_in     = ple_pkg::STATE_WALK;
                        walk_list_in = 1'b1;
                        step_in      = '0;
                     end
                  end
                  ple_pkg::OP_SEARCH: begin
                     if (is_empty) begin
                        status = ple_pkg::STATUS_NOTFOUND;
                     end else begin
                        emit_now      = 1'b0;
                        state_in      = ple_pkg::STATE_WALK;
                        walk_list_in  = 1'b0;
                        step_in       = '0;
                        hits_in       = '0;
                        key_in        = req_data.value;
                        pend_valid_in = 1'b0;
                     end
                  end
                  default: begin
                     status = ple_pkg::STATUS_OK;
                  end
               endcase
               if (emit_now) begin
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.status         = status;
                  rsp_data_in.item_value     = '0;
                  rsp_data_in.item_position  = '0;
                  rsp_data_in.count          = 6'(len_in);
                  rsp_data_in.last           = 1'b1;
               end
            end
         end
         ple_pkg::STATE_WALK: begin
            if (can_emit) begin
               cmd.op  = ple_pkg::CELL_ROTATE;
               step_in = step_ff + 1'b1;
               if (walk_list_ff) begin
                  if (in_range && (int'(step_ff) < ple_pkg::MAX_RESULTS)) begin
                     rsp_valid_in              = 1'b1;
                     rsp_data_in.status        = ple_pkg::STATUS_OK;
                     rsp_data_in.item_value    = head;
                     rsp_data_in.item_position = 5'(step_ff);
                     rsp_data_in.count         = 6'(len_ff);
                     rsp_data_in.last          =
                        ((LW'(step_ff) + LW'(1)) == len_ff) ||
                        (int'(step_ff) == ple_pkg::MAX_RESULTS - 1);
                  end
               end else if (in_range && (hits_ff < ple_pkg::HIT_W'(ple_pkg::MAX_RESULTS))
                            && (head == key_ff)) begin
                  // A new match releases the one held before it.
                  hits_in       = hits_ff + 1'b1;
                  pend_valid_in = 1'b1;
                  pend_value_in = head;
                  pend_pos_in   = 5'(step_ff);
                  if (pend_valid_ff) begin
                     rsp_valid_in              = 1'b1;
                     rsp_data_in.status        = ple_pkg::STATUS_OK;
                     rsp_data_in.item_value    = pend_value_ff;
                     rsp_data_in.item_position = pend_pos_ff;
                     rsp_data_in.count         = 6'(len_ff);
                     rsp_data_in.last          = 1'b0;
                  end
               end
               if (step_ff == IW'(CAPACITY - 1)) begin
                  state_in = walk_list_ff ? ple_pkg::STATE_IDLE : ple_pkg::STATE_FINISH;
               end
            end
         end
         ple_pkg::STATE_FINISH: begin
            if (can_emit) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.count  = 6'(len_ff);
               rsp_data_in.last   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in.status        = ple_pkg::STATUS_OK;
                  rsp_data_in.item_value    = pend_value_ff;
                  rsp_data_in.item_position = pend_pos_ff;
               end else begin
                  rsp_data_in.status        = ple_pkg::STATUS_NOTFOUND;
                  rsp_data_in.item_value    = '0;
                  rsp_data_in.item_position = '0;
               end
               state_in = ple_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = ple_pkg::STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ple_pkg::STATE_IDLE;
         len_ff        <= '0;
         step_ff       <= '0;
         hits_ff       <= '0;
         walk_list_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         step_ff       <= step_in;
         hits_ff       <= hits_in;
         walk_list_ff  <= walk_list_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      pend_value_ff <= pend_value_in;
      pend_pos_ff   <= pend_pos_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* bench/positional_list_engine_top_tb.sv */
`timescale 1ns / 1ps

module positional_list_engine_top_tb;
   import ple_pkg::*;

   localparam int CAPACITY    = 32;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 64;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   positional_list_engine_top #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // Free-running 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the list that the predictor keeps in step with the block.
   logic signed [DATA_W-1:0] list_vals [0:CAPACITY-1];
   int                       list_len = 0;

   // Requests waiting to be driven, and results the block still owes us.
   req_type pending_reqs [$];
   rsp_type expected_rsps [$];

   int             mismatch_count = 0;
   int             cycle_count = 0;
   logic           req_taken = 1'b0;
   int             burst_left = 1;
   int             gap_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   rsp_type        oldest_rsp;

   // ------------------------------------------------------------------
   // List predictor.
   // ------------------------------------------------------------------

   function automatic rsp_type make_rsp(logic [2:0] st, logic signed [DATA_W-1:0] v, int pos,
                                        logic fin);
      rsp_type r;
      r.status        = st;
      r.item_value    = v;
      r.item_position = pos[4:0];
      r.count         = list_len[5:0];
      r.last          = fin;
      return r;
   endfunction

   function automatic logic [2:0] insert_entry(int pos, logic signed [DATA_W-1:0] v);
      if (list_len >= CAPACITY) return STATUS_FULL;
      if (pos > list_len) return STATUS_BADPOS;
      for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
      list_vals[pos] = v;
      list_len++;
      return STATUS_OK;
   endfunction

   // The empty check deliberately comes before the position check.
   function automatic logic [2:0] delete_entry(int pos);
      if (list_len == 0) return STATUS_EMPTY;
      if (pos >= list_len) return STATUS_BADPOS;
      for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
      list_len--;
      return STATUS_OK;
   endfunction

   // Updates the shadow list for one accepted request and queues every result
   // that the request should produce, in order.
   task automatic apply_request(input req_type r);
      logic [2:0] st;
      int         n;
      st = STATUS_OK;
      n  = 0;
      case (r.op)
         OP_INS_FRONT: st = insert_entry(0, r.value);
         OP_INS_AT:    st = insert_entry(int'(r.position), r.value);
         OP_INS_BACK:  st = insert_entry(list_len, r.value);
         OP_DEL_FRONT: st = delete_entry(0);
         OP_DEL_AT:    st = delete_entry(int'(r.position));
         OP_DEL_BACK:  st = (list_len == 0) ? STATUS_EMPTY : delete_entry(list_len - 1);
         OP_LIST: begin
            if (list_len == 0) begin
               st = STATUS_EMPTY;
            end else begin
               for (int i = 0; i < list_len && n < MAX_RESULTS; i++) begin
                  expected_rsps.push_back(make_rsp(STATUS_OK, list_vals[i], i,
                                                   (i + 1 == list_len) || (n + 1 == MAX_RESULTS)));
                  n++;
               end
            end
         end
         OP_SEARCH: begin
            for (int i = 0; i < list_len && n < MAX_RESULTS; i++) begin
               if (list_vals[i] == r.value) begin
                  expected_rsps.push_back(make_rsp(STATUS_OK, r.value, i, 1'b0));
                  n++;
               end
            end
            if (n == 0) st = STATUS_NOTFOUND;
            else expected_rsps[expected_rsps.size()-1].last = 1'b1;
         end
         OP_COUNT: ;
         // Unused operation codes leave the list alone and report the count.
         default: ;
      endcase
      if (n == 0) expected_rsps.push_back(make_rsp(st, '0, 0, 1'b1));
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------

   task automatic push_req(logic [3:0] op, logic signed [DATA_W-1:0] v, int pos);
      req_type r;
      r.op       = op;
      r.value    = v;
      r.position = pos[POS_W-1:0];
      pending_reqs.push_back(r);
   endtask

   // Values come mostly from a small pool so that searches find several
   // matches, with fully random words mixed in to toggle every bit.
   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 3) return $urandom;
      case ($urandom_range(0, 5))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return -32'sd1;
         3:       return 32'sd0;
         4:       return 32'sd7;
         default: return 32'sd42;
      endcase
   endfunction

   // Positions mostly near the live range; now and then anywhere in 0..63.
   function automatic int pick_position();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, CAPACITY + 1);
   endfunction

   function automatic logic [3:0] pick_insert_op();
      case ($urandom_range(0, 2))
         0:       return OP_INS_FRONT;
         1:       return OP_INS_AT;
         default: return OP_INS_BACK;
      endcase
   endfunction

   function automatic logic [3:0] pick_delete_op();
      case ($urandom_range(0, 2))
         0:       return OP_DEL_FRONT;
         1:       return OP_DEL_AT;
         default: return OP_DEL_BACK;
      endcase
   endfunction

   function automatic logic [3:0] pick_query_op();
      case ($urandom_range(0, 2))
         0:       return OP_LIST;
         1:       return OP_SEARCH;
         default: return OP_COUNT;
      endcase
   endfunction

   // Empties the list, fills it with one value past capacity and then asks
   // for a search that matches every entry, so the run reaches its cap.
   task automatic push_uniform_fill();
      logic signed [DATA_W-1:0] v;
      v = pick_value();
      repeat (CAPACITY + 2) push_req(OP_DEL_BACK, pick_value(), 0);
      repeat (CAPACITY + 2) push_req(OP_INS_BACK, v, 0);
      push_req(OP_SEARCH, v, 0);
      push_req(OP_LIST, 0, 0);
      push_req(OP_INS_AT, pick_value(), 0);
      push_req(OP_DEL_AT, 0, 40);
      push_req(OP_COUNT, 0, 0);
   endtask

   // ------------------------------------------------------------------
   // Main sequence: build the stimulus, release reset, wait for the end.
   // ------------------------------------------------------------------

   initial begin
      int generated;
      int seg_len;
      int kind;

      // Directed part. Every query and delete on an empty list first, plus an
      // unknown code and a bad insert, then a short list built from the extreme values.
      push_req(OP_LIST, 0, 0);
      push_req(OP_SEARCH, 0, 0);
      push_req(OP_DEL_FRONT, 0, 0);
      push_req(OP_DEL_AT, 0, 5);          // empty wins over the bad position
      push_req(OP_DEL_BACK, 0, 0);
      push_req(OP_COUNT, 0, 0);
      push_req(4'hf, 32'sh7fff_ffff, 63);
      push_req(OP_INS_AT, 5, 1);          // past the end of an empty list
      push_req(OP_INS_AT, 32'sh8000_0000, 0);
      push_req(OP_INS_FRONT, 32'sh7fff_ffff, 0);
      push_req(OP_INS_BACK, -1, 0);
      push_req(OP_INS_AT, 0, 3);          // position equal to the length
      push_req(OP_INS_AT, 9, 63);
      push_req(OP_INS_AT, 32'sh5555_5555, 2);
      push_req(OP_LIST, 0, 0);
      push_req(OP_SEARCH, -1, 0);
      push_req(OP_SEARCH, 32'sh1234, 0);  // no match on a non-empty list
      push_req(OP_DEL_AT, 0, 5);          // position not below the length
      push_req(OP_DEL_AT, 0, 63);
      push_req(OP_DEL_AT, 0, 1);
      push_req(OP_DEL_FRONT, 0, 0);
      push_req(OP_DEL_BACK, 0, 0);
      push_req(4'h9, 32'sh2aaa_aaaa, 42);
      push_req(OP_LIST, 0, 0);
      push_req(OP_COUNT, 0, 0);

      // Random part in segments: fill phases push the list into the full
      // store, drain phases empty it, mixed phases add noise.
      generated = pending_reqs.size();
      push_uniform_fill();
      while (pending_reqs.size() - generated < RANDOM_ITEMS) begin
         kind    = $urandom_range(0, 9);
         seg_len = $urandom_range(30, 45);
         if (kind == 0) begin
            push_uniform_fill();
         end else if (kind < 5) begin
            repeat (seg_len) begin
               if ($urandom_range(0, 99) < 85) push_req(pick_insert_op(), pick_value(),
                                                        pick_position());
               else push_req(pick_query_op(), pick_value(), pick_position());
            end
         end else if (kind < 8) begin
            repeat (seg_len) begin
               if ($urandom_range(0, 99) < 85) push_req(pick_delete_op(), pick_value(),
                                                        pick_position());
               else push_req(pick_query_op(), pick_value(), pick_position());
            end
         end else begin
            repeat (seg_len / 2) begin
               push_req(4'($urandom_range(0, 15)), pick_value(), pick_position());
            end
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every request went in and every result came back.
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         $display("ERROR: %0d results never arrived", expected_rsps.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("positional_list_engine_top_tb passed");
      end else begin
         $display("positional_list_engine_top_tb failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Request driver: bursts of transactions separated by random gaps. A
   // transaction that is still stalled stays on the bus unchanged.
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) apply_request(req_data);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               // A quarter of the bursts follow on with no gap at all.
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side: the stall pattern switches between quiet, light, heavy
   // and toggling stretches of random length.
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      if (mismatch_count < 10) begin
         $display("ERROR: %s: expected status %0d value %0d pos %0d count %0d last %0b",
                  what, want.status, want.item_value, want.item_position, want.count,
                  want.last);
         $display("       got status %0d value %0d pos %0d count %0d last %0b",
                  got.status, got.item_value, got.item_position, got.count, got.last);
      end
      mismatch_count++;
   endtask

   // Monitor: every accepted result is checked against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_data);
         end else begin
            oldest_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== oldest_rsp.status ||
                rsp_data.item_value !== oldest_rsp.item_value ||
                rsp_data.item_position !== oldest_rsp.item_position ||
                rsp_data.count !== oldest_rsp.count ||
                rsp_data.last !== oldest_rsp.last) begin
               report_mismatch("result mismatch", oldest_rsp, rsp_data);
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("positional_list_engine_top_tb failed");
         $finish;
      end
   end

endmodule
